/* rtl/dzvc_pkg.sv */
// Shared types and constants for the delta / zigzag / varint codec.
// No dependencies; imported by every module of the codec.
package dzvc_pkg;

   // Sample and varint geometry
   localparam int DATA_W  = 64;
   localparam int GROUP_W = 7;
   localparam int BYTE_W  = 8;
   localparam int SHIFT_W = 7;

   // Group position limits: last real group sits at bit 63, 70 marks overlong
   localparam logic [SHIFT_W-1:0] SHIFT_LAST     = SHIFT_W'(63);
   localparam logic [SHIFT_W-1:0] SHIFT_OVERLONG = SHIFT_W'(70);
   localparam logic [SHIFT_W-1:0] SHIFT_STEP     = SHIFT_W'(GROUP_W);

   // Mode register codes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // One classified item as it travels from front to back.
   // payload holds the sample for encode, the 7-bit group for decode.
   typedef struct packed {
      logic              start_new;
      logic              decode;
      logic              cont;
      logic [DATA_W-1:0] payload;
   } item_type;

endpackage

/* rtl/dzvc_front.sv */
// Front end of the codec: mode register, input beat acceptance and classification.
// Depends on dzvc_pkg; feeds dzvc_queue.
module dzvc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_start_new,
   input  logic [63:0]             req_sample,
   input  logic [7:0]              req_code_byte,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   output logic                    push_valid,
   input  logic                    push_ready,
   output dzvc_pkg::item_type      push_item
);
   import dzvc_pkg::*;

   logic mode_ff;
   logic mode_in;

   // Mode register, written directly by the configuration port
   always_comb begin
      mode_in = mode_ff;
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Classify the beat: keep only what the back end needs for this mode
   always_comb begin
      push_item.start_new = req_start_new;
      push_item.decode    = (mode_ff == MODE_DECODE);
      push_item.cont      = 1'b0;
      push_item.payload   = req_sample;
      if (mode_ff == MODE_DECODE) begin
         push_item.cont    = req_code_byte[BYTE_W-1];
         push_item.payload = {{(DATA_W-GROUP_W){1'b0}}, req_code_byte[GROUP_W-1:0]};
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

/* rtl/dzvc_queue.sv */
// Short flop-based queue decoupling the codec front end from the back end.
// Depends on dzvc_pkg (depth and item type).
module dzvc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  dzvc_pkg::item_type      push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output dzvc_pkg::item_type      pop_item
);
   import dzvc_pkg::*;

   item_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/dzvc_back.sv */
// Back end of the codec: delta/zigzag state, varint byte emitter, decode accumulator
// and the result output register. Depends on dzvc_pkg; fed by dzvc_queue.
module dzvc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  dzvc_pkg::item_type      pop_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic [63:0]             rsp_out_value,
   output logic                    rsp_last,
   output logic                    rsp_too_long
);
   import dzvc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EMIT = 3'b010,
      ST_SUM  = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [DATA_W-1:0]   prev_ff,  prev_in;
   logic [DATA_W-1:0]   acc_ff,   acc_in;
   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic [DATA_W-1:0]   zz_ff,    zz_in;
   logic                ovl_ff,   ovl_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   byte_ff,  byte_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic                last_ff,  last_in;
   logic                tlong_ff, tlong_in;

   logic                out_free;
   logic [DATA_W-1:0]   prev_base, acc_base, delta, group_bits, acc_merged, unmapped;
   logic [SHIFT_W-1:0]  shift_base;
   logic                more;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE);

   // A new sequence starts from cleared state
   assign prev_base  = pop_item.start_new ? '0 : prev_ff;
   assign acc_base   = pop_item.start_new ? '0 : acc_ff;
   assign shift_base = pop_item.start_new ? '0 : shift_ff;

   // Encode path: wrapping delta then zigzag map
   assign delta = pop_item.payload - prev_base;

   // Decode path: drop groups past bit 63 (shift above it means overlong)
   assign group_bits = (shift_base <= SHIFT_LAST) ?
                       (pop_item.payload << shift_base[5:0]) : '0;
   assign acc_merged = acc_base | group_bits;

   // Zigzag unmap of the finished accumulator
   assign unmapped = (acc_ff >> 1) ^ {DATA_W{acc_ff[0]}};

   // Varint byte: continuation while bits remain above the low group
   assign more = (zz_ff[DATA_W-1:GROUP_W] != '0);

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      acc_in       = acc_ff;
      shift_in     = shift_ff;
      zz_in        = zz_ff;
      ovl_in       = ovl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      byte_in      = byte_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      tlong_in     = tlong_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               prev_in  = prev_base;
               acc_in   = acc_base;
               shift_in = shift_base;
               if (!pop_item.decode) begin
                  zz_in    = {delta[DATA_W-2:0], 1'b0} ^ {DATA_W{delta[DATA_W-1]}};
                  prev_in  = pop_item.payload;
                  state_in = ST_EMIT;
               end else begin
                  acc_in = acc_merged;
                  if (pop_item.cont) begin
                     shift_in = (shift_base <= SHIFT_LAST) ? shift_base + SHIFT_STEP
                                                           : SHIFT_OVERLONG;
                  end else begin
                     ovl_in   = (shift_base >= SHIFT_OVERLONG);
                     state_in = ST_SUM;
                  end
               end
            end
         end
         ST_EMIT: begin
            // one varint byte per free output slot
            if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_in      = {more, zz_ff[GROUP_W-1:0]};
               value_in     = '0;
               last_in      = !more;
               tlong_in     = 1'b0;
               zz_in        = zz_ff >> GROUP_W;
               if (!more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SUM: begin
            // reconstruct the sample and close the varint
            if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_in      = '0;
               value_in     = prev_ff + unmapped;
               last_in      = 1'b1;
               tlong_in     = ovl_ff;
               prev_in      = prev_ff + unmapped;
               acc_in       = '0;
               shift_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and codec state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         acc_ff       <= '0;
         shift_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         acc_ff       <= acc_in;
         shift_ff     <= shift_in;
      end
   end

   // Working and result payload registers
   always_ff @(posedge clock) begin
      zz_ff    <= zz_in;
      ovl_ff   <= ovl_in;
      byte_ff  <= byte_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      tlong_ff <= tlong_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_value = value_ff;
   assign rsp_last      = last_ff;
   assign rsp_too_long  = tlong_ff;

endmodule

/* rtl/delta_zigzag_varint_codec.sv */
// Delta + zigzag + varint codec, top level. Encode: a sample is loaded, then the byte
// emitter gives one byte per cycle unless the output stalls, then takes the next item.
// Decode: a continuation byte is accumulated; a final byte is accumulated, then added.
// A 2-entry queue feeds the back end, which drives the result output register.
// Synchronous active-high reset clears mode (encode), queue, state and output valid.
// Depends on dzvc_pkg, dzvc_front, dzvc_queue and dzvc_back.
module delta_zigzag_varint_codec (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_start_new,
   input  logic signed [63:0] req_sample,
   input  logic [7:0]         req_code_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic signed [63:0] rsp_out_value,
   output logic               rsp_last,
   output logic               rsp_too_long,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);
   import dzvc_pkg::*;

   logic        push_valid, push_ready, pop_valid, pop_ready;
   item_type    push_item, pop_item;
   logic [63:0] out_value;

   // Accept and classify beats
   dzvc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_new (req_start_new),
      .req_sample    (req_sample),
      .req_code_byte (req_code_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   // Decoupling queue
   dzvc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Execute and emit results
   dzvc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_item      (pop_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_value (out_value),
      .rsp_last      (rsp_last),
      .rsp_too_long  (rsp_too_long)
   );

   assign rsp_out_value = out_value;

endmodule

/* dv/tb.sv */
// Self-checking testbench for delta_zigzag_varint_codec: directed table, then random phases.
// An in-bench predictor checks every result beat in both encode and decode modes.
// Depends on dzvc_pkg and the codec RTL.
module tb;
   import dzvc_pkg::*;

   localparam logic [63:0] SMP_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMP_MIN = 64'h8000_0000_0000_0000;
   localparam logic [7:0] CONT_FLAG = 8'h80;
   localparam int MAX_BYTES = 10;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS = 48;
   localparam int PHASES = 8;

   // One result beat as seen on the rsp_ channel
   typedef struct packed {
      logic [7:0]  out_byte;
      logic [63:0] out_value;
      logic        last;
      logic        too_long;
   } rsp_beat_t;

   localparam rsp_beat_t NO_BEAT = '0;

   // One row of the directed table; typed rows carry the final beat in full
   typedef struct {
      logic        mode;
      logic        start_new;
      logic [63:0] sample;
      logic [7:0]  code_byte;
      bit          typed;
      rsp_beat_t   beat;
   } stim_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_start_new = 1'b0;
   logic signed [63:0] req_sample = '0;
   logic [7:0]         req_code_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic signed [63:0] rsp_out_value;
   logic               rsp_last;
   logic               rsp_too_long;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;

   // Predictor state, mirrors the block
   logic               codec_mode = MODE_ENCODE;
   logic [63:0]        last_sample = '0;
   logic [63:0]        varint_acc = '0;
   logic [SHIFT_W-1:0] varint_shift = '0;

   rsp_beat_t   expected_beats [$];
   stim_row_t   dir_rows [$];
   int unsigned mismatch_count = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;

   delta_zigzag_varint_codec u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_start_new (req_start_new),
      .req_sample    (req_sample),
      .req_code_byte (req_code_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last),
      .rsp_too_long  (rsp_too_long),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] zigzag_fold(input logic [63:0] v);
      return (v << 1) ^ {64{v[63]}};
   endfunction

   function automatic logic [63:0] zigzag_unfold(input logic [63:0] v);
      return (v >> 1) ^ {64{v[0]}};
   endfunction

   // Works out the beats caused by one accepted input beat and queues them
   function automatic void predict_codec_beats(input logic sn, input logic [63:0] smp,
                                               input logic [7:0] cb);
      logic [63:0] z;
      rsp_beat_t   b;
      bit          overlong;
      if (sn) begin
         last_sample = '0;
         varint_acc = '0;
         varint_shift = '0;
      end
      if (codec_mode == MODE_ENCODE) begin
         z = zigzag_fold(smp - last_sample);
         last_sample = smp;
         for (int n = 0; n < MAX_BYTES; n++) begin
            b = '0;
            b.last = (z < 64'(CONT_FLAG));
            b.out_byte = b.last ? z[7:0] : (CONT_FLAG | {1'b0, z[6:0]});
            expected_beats.push_back(b);
            if (b.last) break;
            z = z >> GROUP_W;
         end
      end else begin
         overlong = (varint_shift >= SHIFT_OVERLONG);
         // groups at bit 64 and beyond fall away; bit 63 keeps one bit
         if (varint_shift <= SHIFT_LAST)
            varint_acc = varint_acc | (64'(cb[6:0]) << varint_shift);
         if (cb[7]) begin
            varint_shift = (varint_shift <= SHIFT_LAST) ? varint_shift + SHIFT_STEP
                                                        : SHIFT_OVERLONG;
         end else begin
            last_sample = last_sample + zigzag_unfold(varint_acc);
            b = '0;
            b.out_value = last_sample;
            b.last = 1'b1;
            b.too_long = overlong;
            expected_beats.push_back(b);
            varint_acc = '0;
            varint_shift = '0;
         end
      end
   endfunction

   // Wait length per beat, with occasional stretches of no idling at all
   function automatic int unsigned draw_wait(inout bit calm);
      if ($urandom_range(0, 15) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 9);
   endfunction

   // Random sample: full range, extremes, or a delta of random width
   function automatic logic [63:0] pick_sample();
      logic [63:0] r;
      int unsigned k;
      r = {$urandom, $urandom};
      k = $urandom_range(1, 63);
      case ($urandom_range(0, 7))
         0: return r;
         1: begin
            case ($urandom_range(0, 3))
               0: return SMP_MIN;
               1: return SMP_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return last_sample + 64'($signed(r) >>> k);
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_beat(input logic sn, input logic [63:0] smp, input logic [7:0] cb,
                            input bit typed = 1'b0, input rsp_beat_t typed_beat = '0);
      int unsigned gap;
      gap = draw_wait(req_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_start_new <= sn;
      req_sample <= smp;
      req_code_byte <= cb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_codec_beats(sn, smp, cb);
      if (typed) expected_beats[expected_beats.size() - 1] = typed_beat;
      @(negedge clock);
   endtask

   // Drain every expected beat, then allow for a trailing continuation byte
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      settle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      codec_mode = m;
   endtask

   // Result checker
   always @(posedge clock) begin : rsp_check
      rsp_beat_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual byte %h value %h",
                     $time, rsp_out_byte, rsp_out_value);
            mismatch_count++;
         end else begin
            want = expected_beats.pop_front();
            check_field("out_byte", 64'(want.out_byte), 64'(rsp_out_byte));
            check_field("out_value", want.out_value, rsp_out_value);
            check_field("last", 64'(want.last), 64'(rsp_last));
            check_field("too_long", 64'(want.too_long), 64'(rsp_too_long));
         end
      end
   end

   // Result side back-pressure
   initial begin : rsp_drive
      int unsigned stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic        first_mode;
      logic        sn;
      logic [7:0]  cb;
      int unsigned left;
      int unsigned nbytes;

      // Encode: zero, small, multi-byte, extremes and wrap-around deltas
      dir_rows.push_back('{MODE_ENCODE, 1'b1, 64'd0, 8'h00, 1'b1, '{8'h00, '0, 1'b1, 1'b0}});
      dir_rows.push_back('{MODE_ENCODE, 1'b0, 64'd63, 8'h00, 1'b1, '{8'h7E, '0, 1'b1, 1'b0}});
      dir_rows.push_back('{MODE_ENCODE, 1'b0, 64'd127, 8'h00, 1'b0, NO_BEAT});
      dir_rows.push_back('{MODE_ENCODE, 1'b1, SMP_MAX, 8'h00, 1'b1, '{8'h01, '0, 1'b1, 1'b0}});
      dir_rows.push_back('{MODE_ENCODE, 1'b0, SMP_MIN, 8'h00, 1'b1, '{8'h02, '0, 1'b1, 1'b0}});
      dir_rows.push_back('{MODE_ENCODE, 1'b0, SMP_MAX, 8'h00, 1'b1, '{8'h01, '0, 1'b1, 1'b0}});
      dir_rows.push_back('{MODE_ENCODE, 1'b1, SMP_MIN, 8'h00, 1'b1, '{8'h01, '0, 1'b1, 1'b0}});
      // code byte ignored while encoding
      dir_rows.push_back('{MODE_ENCODE, 1'b0, '1, 8'hFF, 1'b0, NO_BEAT});
      // Decode carries the previous sample over from encode
      dir_rows.push_back('{MODE_DECODE, 1'b0, 64'd0, 8'h02, 1'b0, NO_BEAT});
      dir_rows.push_back('{MODE_DECODE, 1'b1, SMP_MAX, 8'h00, 1'b1, '{8'h00, '0, 1'b1, 1'b0}});
      dir_rows.push_back('{MODE_DECODE, 1'b0, 64'd0, 8'h7F, 1'b0, NO_BEAT});
      // Overlong varint: ten full groups, a saturated empty group, then the end
      dir_rows.push_back('{MODE_DECODE, 1'b1, 64'd0, 8'hFF, 1'b0, NO_BEAT});
      repeat (9) dir_rows.push_back('{MODE_DECODE, 1'b0, 64'd0, 8'hFF, 1'b0, NO_BEAT});
      dir_rows.push_back('{MODE_DECODE, 1'b0, 64'd0, 8'h80, 1'b0, NO_BEAT});
      dir_rows.push_back('{MODE_DECODE, 1'b0, 64'd0, 8'h7F, 1'b1, '{8'h00, SMP_MIN, 1'b1, 1'b1}});
      // Partial varint survives an encode beat in between
      dir_rows.push_back('{MODE_DECODE, 1'b0, 64'd0, 8'h81, 1'b0, NO_BEAT});
      dir_rows.push_back('{MODE_ENCODE, 1'b0, 64'd5, 8'h00, 1'b0, NO_BEAT});
      dir_rows.push_back('{MODE_DECODE, 1'b0, 64'd0, 8'h01, 1'b0, NO_BEAT});

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (dir_rows[i]) begin
         if (i == 0 || dir_rows[i].mode != codec_mode) write_mode(dir_rows[i].mode);
         send_beat(dir_rows[i].start_new, dir_rows[i].sample, dir_rows[i].code_byte,
                   dir_rows[i].typed, dir_rows[i].beat);
      end

      // Random phases, alternating mode
      first_mode = logic'($urandom_range(0, 1));
      for (int ph = 0; ph < PHASES; ph++) begin
         write_mode(first_mode ^ logic'(ph[0]));
         if (codec_mode == MODE_ENCODE) begin
            repeat (PHASE_ITEMS) begin
               sn = ($urandom_range(0, 15) == 0);
               send_beat(sn, pick_sample(), 8'($urandom_range(0, 255)));
            end
         end else begin
            // mostly well-formed varints of random length; some noise and overlong ones
            left = PHASE_ITEMS;
            while (left != 0) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: nbytes = $urandom_range(1, 2);
                  5, 6, 7: nbytes = $urandom_range(3, 6);
                  8: nbytes = $urandom_range(7, MAX_BYTES);
                  default: nbytes = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 3);
               endcase
               for (int i = 0; i < nbytes && left != 0; i++) begin
                  cb = {(i != nbytes - 1), 7'($urandom_range(0, 127))};
                  if ($urandom_range(0, 11) == 0) cb = 8'($urandom_range(0, 255));
                  sn = ($urandom_range(0, 23) == 0);
                  send_beat(sn, {$urandom, $urandom}, cb);
                  left--;
               end
            end
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
